FILE: hw/rtl/csr_complex_spmv_row_unit_assert.svh
// Assertion macros for the CSR row unit
`ifndef CSR_COMPLEX_SPMV_ROW_UNIT_ASSERT_SVH
`define CSR_COMPLEX_SPMV_ROW_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CSR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSR_ASSERT_IMPLY(lbl, ante, cons)
`define CSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/csr_spmv_pkg.sv
package csr_spmv_pkg;
  localparam int NZ_DEPTH  = 4096;
  localparam int NZ_AW     = 12;
  localparam int ROWS      = 1024;
  localparam int ROW_AW    = 10;
  localparam int PTR_DEPTH = ROWS + 1;
  localparam int PTR_AW    = 11;
  localparam int PTR_W     = 13;
  localparam int COL_W     = 10;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 80;
  localparam int QDEPTH    = 4;
  localparam int Q_AW      = 2;

  typedef enum logic [1:0] {
    KIND_NZ  = 2'd0,
    KIND_PTR = 2'd1,
    KIND_VEC = 2'd2,
    KIND_ROW = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [11:0]        index;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [COL_W-1:0]   column;
    logic [PTR_W-1:0]   pointer;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_END,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       idle;
    logic       finish;
    logic [3:0] pipe_v;
  } bk_status_t;

  function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] lim;
    lim = PTR_W'(NZ_DEPTH);
    return (p > lim) ? lim : p;
  endfunction

  function automatic logic signed [31:0] saturate(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> FRAC_BITS;
    if (&sh[ACC_W-1:31] || ~|sh[ACC_W-1:31]) return sh[31:0];
    return sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction
endpackage

FILE: hw/rtl/csr_spmv_ram.sv
module csr_spmv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/csr_spmv_front.sv
module csr_spmv_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  csr_spmv_pkg::item_t       in_item,
  output csr_spmv_pkg::item_t       head,
  output logic                      head_valid,
  input  logic                      head_pop
);
  import csr_spmv_pkg::*;

  item_t           q [QDEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            keep;
  logic            wr_en;
  logic            rd_en;

  always_comb begin
    unique case (in_item.kind)
      KIND_NZ:  keep = 1'b1;
      KIND_PTR: keep = {1'b0, in_item.index} <= 13'(ROWS);
      KIND_VEC: keep = {1'b0, in_item.index} < 13'(ROWS);
      KIND_ROW: keep = {1'b0, in_item.index} < 13'(ROWS);
      default:  keep = 1'b0;
    endcase
  end

  assign full       = (count == (Q_AW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign wr_en      = push && !full && keep;
  assign rd_en      = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_AW+1)'(wr_en) - (Q_AW+1)'(rd_en);
    end
  end
endmodule

FILE: hw/rtl/csr_spmv_back.sv
module csr_spmv_back (
  input  logic                       clk,
  input  logic                       rst,
  input  csr_spmv_pkg::item_t        head,
  input  logic                       head_valid,
  output logic                       head_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [csr_spmv_pkg::ROW_AW-1:0] row,
  output logic signed [31:0]         result_re,
  output logic signed [31:0]         result_im,
  output csr_spmv_pkg::bk_status_t   status
);
  import csr_spmv_pkg::*;

  state_t state, state_next;

  logic [ROW_AW-1:0]  cur_row;
  logic [PTR_W-1:0]   start_ptr;
  logic [PTR_W-1:0]   end_ptr;
  logic [PTR_W-1:0]   j;
  logic               issue;

  logic               rs_we, nz_we, vec_we;
  logic [PTR_AW-1:0]  rs_raddr;
  logic [PTR_W-1:0]   rs_rdata;
  logic [NZ_AW-1:0]   nz_raddr;
  logic [64+COL_W-1:0] nz_rdata;
  logic [ROW_AW-1:0]  vec_raddr;
  logic [63:0]        vec_rdata;

  logic               v1, v2, v3, v4;
  logic [63:0]        a_q;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [64:0] s_re, s_im;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic               out_valid;
  logic               out_load;

  csr_spmv_ram #(.WIDTH(PTR_W), .DEPTH(PTR_DEPTH)) u_rs (
    .clk(clk), .we(rs_we), .waddr(head.index[PTR_AW-1:0]), .wdata(head.pointer),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  csr_spmv_ram #(.WIDTH(64 + COL_W), .DEPTH(NZ_DEPTH)) u_nz (
    .clk(clk), .we(nz_we), .waddr(head.index[NZ_AW-1:0]),
    .wdata({head.column, head.im, head.re}),
    .raddr(nz_raddr), .rdata(nz_rdata)
  );

  csr_spmv_ram #(.WIDTH(64), .DEPTH(ROWS)) u_vec (
    .clk(clk), .we(vec_we), .waddr(head.index[ROW_AW-1:0]), .wdata({head.im, head.re}),
    .raddr(vec_raddr), .rdata(vec_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (head_valid && head.kind == KIND_ROW) state_next = ST_START;
      ST_START:  state_next = ST_END;
      ST_END:    state_next = ST_WALK;
      ST_WALK:   if (!issue) state_next = ST_DRAIN;
      ST_DRAIN:  if (!(v1 || v2 || v3 || v4)) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || pop) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_pop = (state == ST_IDLE) && head_valid;
    rs_we    = head_pop && head.kind == KIND_PTR;
    nz_we    = head_pop && head.kind == KIND_NZ;
    vec_we   = head_pop && head.kind == KIND_VEC;
    rs_raddr = (state == ST_IDLE) ? head.index[PTR_AW-1:0]
                                  : PTR_AW'({1'b0, cur_row} + 11'd1);
    issue    = (state == ST_WALK) && (j < end_ptr);
    nz_raddr = j[NZ_AW-1:0];
    vec_raddr = nz_rdata[64 +: COL_W];
    out_load = (state == ST_FINISH) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop && head.kind == KIND_ROW) cur_row <= head.index[ROW_AW-1:0];
    if (state == ST_START) begin
      start_ptr <= clamp_ptr(rs_rdata);
      acc_re    <= '0;
      acc_im    <= '0;
    end
    if (state == ST_END) begin
      end_ptr <= clamp_ptr(rs_rdata);
      j       <= start_ptr;
    end
    if (issue) j <= j + 1'b1;
    a_q  <= nz_rdata[63:0];
    p_rr <= $signed(a_q[31:0])  * $signed(vec_rdata[31:0]);
    p_ii <= $signed(a_q[63:32]) * $signed(vec_rdata[63:32]);
    p_ri <= $signed(a_q[31:0])  * $signed(vec_rdata[63:32]);
    p_ir <= $signed(a_q[63:32]) * $signed(vec_rdata[31:0]);
    s_re <= 65'(p_rr) - 65'(p_ii);
    s_im <= 65'(p_ri) + 65'(p_ir);
    if (v4) begin
      acc_re <= acc_re + ACC_W'(s_re);
      acc_im <= acc_im + ACC_W'(s_im);
    end
    if (out_load) begin
      row       <= cur_row;
      result_re <= saturate(acc_re);
      result_im <= saturate(acc_im);
    end
  end

  assign empty         = !out_valid;
  assign status.idle   = (state == ST_IDLE);
  assign status.finish = out_load;
  assign status.pipe_v = {v4, v3, v2, v1};
endmodule

FILE: hw/rtl/csr_complex_spmv_row_unit.sv
// Complex CSR sparse matrix-vector row unit, Q16.16. Push load items to fill
// the nonzero, row-pointer and vector memories, then push a compute item
// naming a row; one saturated complex sum per row comes out of the output
// register. Loads are taken from the queue only while no row is in progress.
// A row goes through the pop, two row-pointer reads, one nonzero per cycle
// through the nonzero read, vector read, multiply and add stages, the step
// that sees the walk end, the pipeline drain and the result write, which
// holds while an unread result sits in the output register. A 4-beat queue
// lets input run ahead of the row walk; items are carried out strictly in
// order.
`include "csr_complex_spmv_row_unit_assert.svh"

module csr_complex_spmv_row_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic [11:0]                       index,
  input  logic signed [31:0]                value_re,
  input  logic signed [31:0]                value_im,
  input  logic [9:0]                        column,
  input  logic [12:0]                       pointer_value,
  output logic                              empty,
  input  logic                              pop,
  output logic [9:0]                        row,
  output logic signed [31:0]                result_re,
  output logic signed [31:0]                result_im
);
  import csr_spmv_pkg::*;

  item_t      in_item;
  item_t      head;
  logic       head_valid;
  logic       head_pop;
  bk_status_t status;

  assign in_item.kind    = kind_t'(kind);
  assign in_item.index   = index;
  assign in_item.re      = value_re;
  assign in_item.im      = value_im;
  assign in_item.column  = column;
  assign in_item.pointer = pointer_value;

  csr_spmv_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .head(head), .head_valid(head_valid), .head_pop(head_pop)
  );

  csr_spmv_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .head_pop(head_pop),
    .empty(empty), .pop(pop), .row(row), .result_re(result_re),
    .result_im(result_im), .status(status)
  );

  `CSR_ASSERT_IMPLY(a_idle_pipe_clear, status.idle, status.pipe_v == 4'b0000)
  `CSR_ASSERT_NEXT(a_finish_fills_out, status.finish, !empty)
  `CSR_ASSERT_IMPLY(a_pop_only_when_idle, head_pop, status.idle && head_valid)
endmodule

FILE: dv/csr_complex_spmv_row_unit_tb.sv
`timescale 1ns / 1ps

module csr_complex_spmv_row_unit_tb;
  import csr_spmv_pkg::*;

  typedef struct {
    logic [9:0]         row;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } row_sum_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [1:0] kind;
  logic [11:0] index;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic [9:0] column;
  logic [12:0] pointer_value;
  logic empty;
  logic pop;
  logic [9:0] row;
  logic signed [31:0] result_re;
  logic signed [31:0] result_im;

  csr_complex_spmv_row_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .index(index),
    .value_re(value_re), .value_im(value_im), .column(column),
    .pointer_value(pointer_value), .empty(empty), .pop(pop), .row(row),
    .result_re(result_re), .result_im(result_im)
  );

  logic [63:0] nz_val[NZ_DEPTH];
  logic [9:0] nz_col[NZ_DEPTH];
  logic [12:0] row_ptr[PTR_DEPTH];
  logic [63:0] vec_val[ROWS];
  bit nz_w[NZ_DEPTH];
  bit ptr_w[PTR_DEPTH];
  bit vec_w[ROWS];

  row_sum_t sum_q[$];
  int errors = 0;
  int beats_sent = 0;
  int sums_checked = 0;
  int sat_hits = 0;
  bit idle_on = 1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("csr_complex_spmv_row_unit test failed");
    $finish;
  end

  function automatic logic signed [31:0] sat_q16(input logic signed [127:0] acc);
    logic signed [127:0] sh;
    sh = acc >>> FRAC_BITS;
    if (&sh[127:31] || ~|sh[127:31]) return sh[31:0];
    return sh[127] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic [12:0] clip_ptr(input logic [12:0] p);
    return (p > 13'(NZ_DEPTH)) ? 13'(NZ_DEPTH) : p;
  endfunction

  function automatic row_sum_t row_dot(input int r);
    row_sum_t s;
    logic signed [127:0] acc_re, acc_im;
    longint ar, ai, br, bi;
    int lo, hi, c;
    acc_re = 0;
    acc_im = 0;
    lo = clip_ptr(row_ptr[r]);
    hi = clip_ptr(row_ptr[r + 1]);
    for (int j = lo; j < hi; j++) begin
      c = nz_col[j];
      if (c < ROWS) begin
        ar = $signed(nz_val[j][31:0]);
        ai = $signed(nz_val[j][63:32]);
        br = $signed(vec_val[c][31:0]);
        bi = $signed(vec_val[c][63:32]);
        acc_re = acc_re + 128'(ar * br) - 128'(ai * bi);
        acc_im = acc_im + 128'(ar * bi) + 128'(ai * br);
      end
    end
    s.row = r[9:0];
    s.re = sat_q16(acc_re);
    s.im = sat_q16(acc_im);
    return s;
  endfunction

  task automatic predict_beat(input kind_t k, input int idx, input logic [31:0] re,
                              input logic [31:0] im, input logic [9:0] col,
                              input logic [12:0] ptr);
    row_sum_t s;
    case (k)
      KIND_NZ: begin
        if (idx < NZ_DEPTH) begin
          nz_val[idx] = {im, re};
          nz_col[idx] = col;
          nz_w[idx] = 1;
        end
      end
      KIND_PTR: begin
        if (idx <= ROWS) begin
          row_ptr[idx] = ptr;
          ptr_w[idx] = 1;
        end
      end
      KIND_VEC: begin
        if (idx < ROWS) begin
          vec_val[idx] = {im, re};
          vec_w[idx] = 1;
        end
      end
      default: begin
        if (idx < ROWS) begin
          s = row_dot(idx);
          if (s.re == 32'sh7fff_ffff || s.re == 32'sh8000_0000) sat_hits++;
          sum_q.push_back(s);
        end
      end
    endcase
  endtask

  task automatic send_beat(input kind_t k, input int idx, input logic [31:0] re,
                           input logic [31:0] im, input logic [9:0] col,
                           input logic [12:0] ptr);
    kind <= k;
    index <= idx[11:0];
    value_re <= re;
    value_im <= im;
    column <= col;
    pointer_value <= ptr;
    push <= 1;
    do @(posedge clk); while (full);
    predict_beat(k, idx, re, im, col, ptr);
    beats_sent++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 8;
      2: return 32'($signed($urandom_range(0, 511)) - 256) <<< 16;
      default: return 32'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  function automatic logic [9:0] rand_col();
    return ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31));
  endfunction

  task automatic load_span(input int r, input int s, input int len);
    send_beat(KIND_PTR, r, $urandom, $urandom, $urandom, 13'(s));
    send_beat(KIND_PTR, r + 1, $urandom, $urandom, $urandom, 13'(s + len));
  endtask

  // fill every entry the row walk will touch, then issue the compute
  task automatic compute_row(input int r);
    int lo, hi;
    if (!ptr_w[r] || !ptr_w[r + 1] ||
        int'(clip_ptr(row_ptr[r + 1])) - int'(clip_ptr(row_ptr[r])) > 16)
      load_span(r, $urandom_range(0, NZ_DEPTH - 9), $urandom_range(0, 8));
    lo = clip_ptr(row_ptr[r]);
    hi = clip_ptr(row_ptr[r + 1]);
    for (int j = lo; j < hi; j++) begin
      if (!nz_w[j]) send_beat(KIND_NZ, j, rand_q16(), rand_q16(), rand_col(), $urandom);
      if (nz_col[j] < ROWS && !vec_w[nz_col[j]])
        send_beat(KIND_VEC, nz_col[j], rand_q16(), rand_q16(), $urandom, $urandom);
    end
    send_beat(KIND_ROW, r, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_sums_drained();
    while (sum_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_basic_rows();
    send_beat(KIND_VEC, 0, 32'h0001_0000, 32'h0000_0000, 0, 0);
    send_beat(KIND_VEC, 1, 32'h0000_8000, 32'hffff_0000, 0, 0);
    send_beat(KIND_VEC, ROWS - 1, 32'hfffe_0000, 32'h0003_0000, 0, 0);
    send_beat(KIND_NZ, 0, 32'h0002_0000, 32'h0001_0000, 0, 0);
    send_beat(KIND_NZ, 1, 32'hffff_ffff, 32'h0000_0001, 1, 0);
    send_beat(KIND_NZ, 2, 32'h8000_0000, 32'h7fff_ffff, ROWS - 1, 0);
    load_span(0, 0, 3);
    send_beat(KIND_ROW, 0, 0, 0, 0, 0);
    load_span(5, 1, 0);
    send_beat(KIND_ROW, 5, 0, 0, 0, 0);
    load_span(7, 3, -2);
    compute_row(7);
  endtask

  task automatic test_saturation();
    send_beat(KIND_VEC, 2, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    for (int j = 10; j < 14; j++)
      send_beat(KIND_NZ, j, 32'h7fff_ffff, 32'h7fff_ffff, 2, 0);
    load_span(9, 10, 4);
    send_beat(KIND_ROW, 9, 0, 0, 0, 0);
    for (int j = 10; j < 14; j++)
      send_beat(KIND_NZ, j, 32'h8000_0000, 32'h0000_0000, 2, 0);
    send_beat(KIND_ROW, 9, 0, 0, 0, 0);
  endtask

  task automatic test_pointer_edges();
    load_span(ROWS - 1, NZ_DEPTH - 3, 8000);
    compute_row(ROWS - 1);
    load_span(20, 13'h1fff, 0);
    send_beat(KIND_ROW, 20, 0, 0, 0, 0);
    load_span(22, NZ_DEPTH, 0);
    send_beat(KIND_ROW, 22, 0, 0, 0, 0);
  endtask

  task automatic test_ignored_beats();
    send_beat(KIND_NZ, 12'hfff, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff, 13'h1fff);
    send_beat(KIND_PTR, ROWS + 1, 0, 0, 0, 13'h1fff);
    send_beat(KIND_PTR, 12'hfff, 0, 0, 0, 13'h1555);
    send_beat(KIND_VEC, ROWS, 32'h5555_5555, 32'haaaa_aaaa, 0, 0);
    send_beat(KIND_ROW, ROWS, 0, 0, 0, 0);
    send_beat(KIND_ROW, 12'hfff, 0, 0, 0, 0);
  endtask

  task automatic test_random_rows(input int target);
    int r, lo, hi;
    while (beats_sent < target) begin
      case ($urandom_range(0, 9))
        0: send_beat(KIND_NZ, $urandom_range(NZ_DEPTH, 4095), $urandom, $urandom,
                     $urandom, $urandom);
        1: send_beat(KIND_PTR, $urandom_range(ROWS + 1, 4095), $urandom, $urandom,
                     $urandom, $urandom);
        2: send_beat(KIND_ROW, $urandom_range(ROWS, 4095), $urandom, $urandom,
                     $urandom, $urandom);
        3: send_beat(KIND_VEC, $urandom_range(0, 4095), rand_q16(), rand_q16(),
                     $urandom, $urandom);
        default: begin
          r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, ROWS - 1);
          if ($urandom_range(0, 1) == 0)
            load_span(r, $urandom_range(0, NZ_DEPTH - 9), $urandom_range(0, 8));
          if (ptr_w[r] && ptr_w[r + 1] && $urandom_range(0, 1) == 0) begin
            lo = clip_ptr(row_ptr[r]);
            hi = clip_ptr(row_ptr[r + 1]);
            for (int j = lo; j < hi && j < lo + 16; j++)
              if ($urandom_range(0, 2) == 0)
                send_beat(KIND_NZ, j, rand_q16(), rand_q16(), rand_col(), $urandom);
          end
          compute_row(r);
        end
      endcase
    end
  endtask

  initial begin
    int pop_hold;
    pop = 0;
    pop_hold = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop_hold--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop_hold = $urandom_range(1, 19) - 1;
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  always @(posedge clk) begin
    row_sum_t e;
    if (!rst && pop && !empty) begin
      if (sum_q.size() == 0) begin
        $display("%0t: unexpected beat row=%0d re=%h im=%h", $time, row, result_re, result_im);
        errors++;
      end else begin
        e = sum_q.pop_front();
        sums_checked++;
        if (row !== e.row) begin
          $display("%0t: row expected %0d actual %0d", $time, e.row, row);
          errors++;
        end
        if (result_re !== e.re) begin
          $display("%0t: result_re expected %h actual %h", $time, e.re, result_re);
          errors++;
        end
        if (result_im !== e.im) begin
          $display("%0t: result_im expected %h actual %h", $time, e.im, result_im);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    rst = 1;
    push = 0;
    kind = KIND_NZ;
    index = 0;
    value_re = 0;
    value_im = 0;
    column = 0;
    pointer_value = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_basic_rows();
    test_saturation();
    test_pointer_edges();
    test_ignored_beats();
    test_random_rows(800);
    push <= 0;
    wait_sums_drained();
    test_random_rows(1200);
    idle_on = 0;
    test_random_rows(1450);
    push <= 0;
    guard = 0;
    while (sum_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    $display("Covered %0d input beats and %0d row sums, %0d saturated real parts,",
             beats_sent, sums_checked, sat_hits);
    $display("with empty, reversed, clamped and ignored items and random stalls.");
    if (errors == 0 && sum_q.size() == 0) begin
      $display("csr_complex_spmv_row_unit test passed");
    end else begin
      $display("csr_complex_spmv_row_unit test failed");
    end
    $finish;
  end
endmodule
